// ===== rtl/core/mprc_pkg.sv =====
`timescale 1ns / 1ps

package mprc_pkg;

	// Field widths of a request and a result.
	localparam int BYTES_W = 9;
	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int SIZE_W  = 12;
	localparam int CODE_W  = 4;
	localparam int SEQ_W   = 7;
	localparam int PKT_W   = 8;

	// Default number of sequence slots tracked per session.
	localparam int SEQ_SLOTS_DEF = 128;

	// Header length and the receive buffer limit, carried in a width that holds the limit.
	localparam int LEN_W = 13;
	localparam logic [LEN_W-1:0] HEADER_BYTES     = LEN_W'(8);
	localparam logic [LEN_W-1:0] MAX_PACKET_BYTES = LEN_W'(508);

	// Header field values.
	localparam logic [2:0]        PRIV_MODE_CODE = 3'd7;
	localparam logic [BYTE_W-1:0] IMPL_NUMBER    = BYTE_W'(3);

	// Reset value of the expected item size register.
	localparam logic [SIZE_W-1:0] EXP_SIZE_RESET = SIZE_W'(60);

	// Request opcodes.
	localparam logic OP_START  = 1'b0;
	localparam logic OP_PACKET = 1'b1;

	// Verdict codes.
	localparam logic [CODE_W-1:0] V_ACCEPT   = 4'd0;
	localparam logic [CODE_W-1:0] V_IDLE     = 4'd1;
	localparam logic [CODE_W-1:0] V_SHORT    = 4'd2;
	localparam logic [CODE_W-1:0] V_MODE     = 4'd3;
	localparam logic [CODE_W-1:0] V_AUTH     = 4'd4;
	localparam logic [CODE_W-1:0] V_NOTRESP  = 4'd5;
	localparam logic [CODE_W-1:0] V_MBZ      = 4'd6;
	localparam logic [CODE_W-1:0] V_IMPL     = 4'd7;
	localparam logic [CODE_W-1:0] V_REMOTE   = 4'd8;
	localparam logic [CODE_W-1:0] V_OVERFLOW = 4'd9;
	localparam logic [CODE_W-1:0] V_TOOLARGE = 4'd10;
	localparam logic [CODE_W-1:0] V_SIZEDIFF = 4'd11;
	localparam logic [CODE_W-1:0] V_DUP      = 4'd12;
	localparam logic [CODE_W-1:0] V_TWOLAST  = 4'd13;
	localparam logic [CODE_W-1:0] V_STARTED  = 4'd14;

	// One packet header request.
	typedef struct packed {
		logic              opcode;
		logic [BYTES_W-1:0] packet_bytes;
		logic [BYTE_W-1:0] mode_byte;
		logic [BYTE_W-1:0] auth_seq_byte;
		logic [BYTE_W-1:0] impl_byte;
		logic [WORD_W-1:0] err_count_word;
		logic [WORD_W-1:0] mbz_size_word;
	} req_t;

	// One check result.
	typedef struct packed {
		logic [CODE_W-1:0] verdict;
		logic [CODE_W-1:0] remote_error;
		logic [SIZE_W-1:0] items_in_packet;
		logic [SIZE_W-1:0] item_bytes;
		logic [SIZE_W-1:0] pad_bytes;
		logic [WORD_W-1:0] item_base;
		logic [WORD_W-1:0] total_items;
		logic [SEQ_W-1:0]  sequence_res;
		logic              response_done;
		logic              session_active;
	} rsp_t;

endpackage

// ===== rtl/core/mprc_stream_if.sv =====
`timescale 1ns / 1ps

// Valid/ready channel that carries one payload per request.
interface mprc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/multi_packet_response_checker_core.sv =====
`timescale 1ns / 1ps

// Checks the header of each packet of a multi-packet private-mode reply and keeps
// the item bookkeeping of the session. A start request (opcode 0) opens a new session;
// every packet request (opcode 1) yields exactly one result with a verdict, the item
// counts and a completion flag. A new request is taken every clock cycle while the input
// is not stalled; each result passes from the input register into the result register
// (one input register, one result register), where it is offered on rsp, and the check
// path between them, with its 12 x 12 size multiply, is combinational. A held
// result stalls the input once both registers are full. The user must write expected_item_size
// through cfg_wr_en and cfg_wr_data only while no request is in flight; the block does not enforce it.
module multi_packet_response_checker_core #(
	parameter int SEQ_SLOTS = mprc_pkg::SEQ_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mprc_stream_if.sink                   req,
	mprc_stream_if.source                 rsp,
	input  logic                          cfg_wr_en,
	input  logic [mprc_pkg::SIZE_W-1:0]   cfg_wr_data
);

	localparam int SLOT_W = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1;
	localparam int SEQ_N  = 1 << mprc_pkg::SEQ_W;

	// Sequence number to slot map, worked out at elaboration.
	function automatic logic [SEQ_N*SLOT_W-1:0] build_slot_lut();
		logic [SEQ_N*SLOT_W-1:0] lut;
		lut = '0;
		for (int i = 0; i < SEQ_N; i++) begin
			lut[i*SLOT_W +: SLOT_W] = SLOT_W'(i % SEQ_SLOTS);
		end
		return lut;
	endfunction

	localparam logic [SEQ_N*SLOT_W-1:0] SLOT_LUT = build_slot_lut();

	// Configuration register.
	logic [mprc_pkg::SIZE_W-1:0] exp_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_size_q <= mprc_pkg::EXP_SIZE_RESET;
		end else if (cfg_wr_en) begin
			exp_size_q <= cfg_wr_data;
		end
	end

	// Input register and result register handshakes.
	logic            valid_s1;
	mprc_pkg::req_t  req_s1;
	logic            rsp_valid_q;
	mprc_pkg::rsp_t  rsp_q;
	logic            advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.payload;
		end
	end

	// Session state.
	logic [SEQ_SLOTS-1:0]          seen_q;
	logic                          last_seq_valid_q;
	logic [mprc_pkg::SEQ_W-1:0]    last_seq_q;
	logic [mprc_pkg::PKT_W-1:0]    pkts_q;
	logic [mprc_pkg::SIZE_W-1:0]   fixed_size_q;
	logic [mprc_pkg::WORD_W-1:0]   item_total_q;
	logic                          active_q;

	logic                          seen_clear;
	logic                          seen_set;
	logic                          last_seq_valid_n;
	logic [mprc_pkg::SEQ_W-1:0]    last_seq_n;
	logic [mprc_pkg::PKT_W-1:0]    pkts_n;
	logic [mprc_pkg::SIZE_W-1:0]   fixed_size_n;
	logic [mprc_pkg::WORD_W-1:0]   item_total_n;
	logic                          active_n;
	mprc_pkg::rsp_t                res;

	// Header fields of the request in the input register.
	logic [mprc_pkg::LEN_W-1:0]    bytes_ext;
	logic [mprc_pkg::LEN_W-1:0]    bytes_c;
	logic [mprc_pkg::SEQ_W-1:0]    seq;
	logic [SLOT_W-1:0]             slot;
	logic [mprc_pkg::CODE_W-1:0]   err_code;
	logic [mprc_pkg::SIZE_W-1:0]   nitems;
	logic [mprc_pkg::SIZE_W-1:0]   isize;
	logic [2*mprc_pkg::SIZE_W-1:0] payload_len;
	logic [2*mprc_pkg::SIZE_W-1:0] room;
	logic [mprc_pkg::WORD_W:0]     total_sum;

	assign bytes_ext   = mprc_pkg::LEN_W'(req_s1.packet_bytes);
	assign bytes_c     = (bytes_ext > mprc_pkg::MAX_PACKET_BYTES) ?
		mprc_pkg::MAX_PACKET_BYTES : bytes_ext;
	assign seq         = req_s1.auth_seq_byte[mprc_pkg::SEQ_W-1:0];
	assign slot        = SLOT_LUT[seq*SLOT_W +: SLOT_W];
	assign err_code    = req_s1.err_count_word[15:12];
	assign nitems      = req_s1.err_count_word[mprc_pkg::SIZE_W-1:0];
	assign isize       = req_s1.mbz_size_word[mprc_pkg::SIZE_W-1:0];
	assign payload_len = nitems * isize;
	assign room        = (2*mprc_pkg::SIZE_W)'(bytes_c - mprc_pkg::HEADER_BYTES);
	assign total_sum   = (mprc_pkg::WORD_W+1)'(item_total_q) +
		(mprc_pkg::WORD_W+1)'(nitems);

	// Checks in priority order and the next session state.
	always_comb begin
		seen_clear       = 1'b0;
		seen_set         = 1'b0;
		last_seq_valid_n = last_seq_valid_q;
		last_seq_n       = last_seq_q;
		pkts_n           = pkts_q;
		fixed_size_n     = fixed_size_q;
		item_total_n     = item_total_q;
		active_n         = active_q;
		res              = '0;
		res.verdict      = mprc_pkg::V_ACCEPT;

		if (req_s1.opcode == mprc_pkg::OP_START) begin
			seen_clear       = 1'b1;
			last_seq_valid_n = 1'b0;
			last_seq_n       = '0;
			pkts_n           = '0;
			fixed_size_n     = '0;
			item_total_n     = '0;
			active_n         = 1'b1;
			res.verdict      = mprc_pkg::V_STARTED;
		end else begin
			res.sequence_res = seq;
			if (!active_q) begin
				res.verdict = mprc_pkg::V_IDLE;
			end else if (bytes_c < mprc_pkg::HEADER_BYTES) begin
				res.verdict = mprc_pkg::V_SHORT;
			end else if (req_s1.mode_byte[2:0] != mprc_pkg::PRIV_MODE_CODE) begin
				res.verdict = mprc_pkg::V_MODE;
			end else if (req_s1.auth_seq_byte[7]) begin
				res.verdict = mprc_pkg::V_AUTH;
			end else if (!req_s1.mode_byte[7]) begin
				res.verdict = mprc_pkg::V_NOTRESP;
			end else if (req_s1.mbz_size_word[15:12] != 4'd0) begin
				res.verdict = mprc_pkg::V_MBZ;
			end else if (req_s1.impl_byte != mprc_pkg::IMPL_NUMBER) begin
				res.verdict = mprc_pkg::V_IMPL;
			end else if (err_code != 4'd0) begin
				res.verdict      = mprc_pkg::V_REMOTE;
				res.remote_error = err_code;
				active_n         = 1'b0;
			end else if (payload_len > room) begin
				res.verdict = mprc_pkg::V_OVERFLOW;
			end else if (isize > exp_size_q) begin
				res.verdict = mprc_pkg::V_TOOLARGE;
			end else if (item_total_q != '0 && fixed_size_q != isize) begin
				res.verdict = mprc_pkg::V_SIZEDIFF;
			end else begin
				// The first packet seen with an empty total fixes the item size.
				if (item_total_q == '0) begin
					fixed_size_n = isize;
				end
				if (seen_q[slot]) begin
					res.verdict = mprc_pkg::V_DUP;
				end else if (!req_s1.mode_byte[6] && last_seq_valid_q) begin
					res.verdict = mprc_pkg::V_TWOLAST;
				end else begin
					if (!req_s1.mode_byte[6]) begin
						last_seq_valid_n = 1'b1;
						last_seq_n       = seq;
					end
					res.items_in_packet = nitems;
					res.pad_bytes       = exp_size_q - isize;
					res.item_base       = item_total_q;
					item_total_n        = total_sum[mprc_pkg::WORD_W] ? '1 :
						total_sum[mprc_pkg::WORD_W-1:0];
					seen_set            = 1'b1;
					pkts_n              = pkts_q + 1'b1;
					// Done when the new packet count is the last sequence number plus one.
					if (last_seq_valid_n && pkts_q == {1'b0, last_seq_n}) begin
						res.response_done = 1'b1;
						active_n          = 1'b0;
					end
				end
			end
		end

		res.item_bytes     = fixed_size_n;
		res.total_items    = item_total_n;
		res.session_active = active_n;
	end

	// State update once the request moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q           <= '0;
			last_seq_valid_q <= 1'b0;
			last_seq_q       <= '0;
			pkts_q           <= '0;
			fixed_size_q     <= '0;
			item_total_q     <= '0;
			active_q         <= 1'b0;
		end else if (advance) begin
			if (seen_clear) begin
				seen_q <= '0;
			end else if (seen_set) begin
				seen_q[slot] <= 1'b1;
			end
			last_seq_valid_q <= last_seq_valid_n;
			last_seq_q       <= last_seq_n;
			pkts_q           <= pkts_n;
			fixed_size_q     <= fixed_size_n;
			item_total_q     <= item_total_n;
			active_q         <= active_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule
